@@ hdl/ame_pkg.sv @@
// Package: shared types, constants and operation codes for the accumulator machine.
`default_nettype none
package ame_pkg;
   localparam int MemWords = 100;
   localparam int WordBits = 32;
   localparam int AddrBits = 7;
   localparam int CntBits  = 6;

   localparam logic [3:0] OP_READ     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_STORE    = 4'd2;
   localparam logic [3:0] OP_ADD      = 4'd3;
   localparam logic [3:0] OP_SUB      = 4'd4;
   localparam logic [3:0] OP_DIV      = 4'd5;
   localparam logic [3:0] OP_MUL      = 4'd6;
   localparam logic [3:0] OP_JUMP     = 4'd7;
   localparam logic [3:0] OP_JUMPNEG  = 4'd8;
   localparam logic [3:0] OP_JUMPZERO = 4'd9;
   localparam logic [3:0] OP_JUMPNZ   = 4'd10;
   localparam logic [3:0] OP_LOADIND  = 4'd11;
   localparam logic [3:0] OP_STOREIND = 4'd12;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIV0  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [3:0]          mode;
      logic [6:0]          operand_address;
      logic signed [31:0]  in_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  accumulator_out;
      logic [6:0]          next_pc;
      logic                branch_taken;
      logic signed [31:0]  memory_word;
      logic [1:0]          status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // write zero at clear address, advance
      logic capture;      // latch request
      logic rd_direct;    // read memory at operand address
      logic rd_pointer;   // read memory at pointer word
      logic execute;      // apply operation after direct read
      logic exec_ind;     // apply indirect operation after pointer read
      logic div_start;
      logic div_step;
      logic div_finish;
      logic mul_finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic div_last;
      logic [3:0] mode;
      logic addr_ok;
      logic div_zero;
   } sts_type;
endpackage
`default_nettype wire

@@ hdl/ame_datapath.sv @@
// Datapath: word memory, accumulator, program counter, divider and multiplier.
`default_nettype none
module ame_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ame_pkg::req_type req,
   input  wire ame_pkg::cmd_type cmd,
   output ame_pkg::sts_type      sts,
   output ame_pkg::rsp_type      result
);
   import ame_pkg::*;

   logic [WordBits-1:0] mem [MemWords];
   logic [WordBits-1:0] rdata_ff;
   logic [AddrBits-1:0] clr_ff, clr_in;
   logic                clr_done_ff;
   req_type             req_ff;
   logic [WordBits-1:0] acc_ff, acc_in;
   logic [AddrBits-1:0] pc_ff, pc_in;
   logic [WordBits-1:0] ptr_ff;
   rsp_type             rsp_ff, rsp_in;
   // divider
   logic [WordBits-1:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic                qneg_ff, qneg_in;
   logic [CntBits-1:0]  dcnt_ff, dcnt_in;
   logic [WordBits-1:0] prod_ff;
   logic [WordBits:0]   trial;
   logic [WordBits-1:0] rd_addr_w;
   logic                we;
   logic [AddrBits-1:0] wa;
   logic [WordBits-1:0] wd;
   logic [AddrBits-1:0] pc_inc;
   logic                addr_ok, ptr_ok, taken;
   logic [WordBits-1:0] abs_a, abs_b, qres;

   assign addr_ok = req_ff.operand_address < AddrBits'(MemWords);
   assign ptr_ok  = !ptr_ff[WordBits-1] && (ptr_ff < WordBits'(MemWords));
   assign pc_inc  = (pc_ff == AddrBits'(MemWords - 1)) ? '0 : pc_ff + 1'b1;
   assign rd_addr_w = cmd.rd_pointer ? rdata_ff : WordBits'(req_ff.operand_address);
   assign abs_a = acc_ff[WordBits-1] ? -acc_ff : acc_ff;
   assign abs_b = rdata_ff[WordBits-1] ? -rdata_ff : rdata_ff;
   assign trial = {rem_ff, quo_ff[WordBits-1]} - {1'b0, dvs_ff};
   assign qres  = qneg_ff ? -quo_ff : quo_ff;

   // Memory write port selection.
   always_comb begin
      we = 1'b0;
      wa = req_ff.operand_address;
      wd = acc_ff;
      if (cmd.clear_step) begin
         we = 1'b1;
         wa = clr_ff;
         wd = '0;
      end else if (cmd.execute && addr_ok && req_ff.mode == OP_READ) begin
         we = 1'b1;
         wd = WordBits'(req_ff.in_value);
      end else if (cmd.execute && addr_ok && req_ff.mode == OP_STORE) begin
         we = 1'b1;
      end else if (cmd.exec_ind && req_ff.mode == OP_STOREIND && ptr_ok) begin
         we = 1'b1;
         wa = AddrBits'(ptr_ff);
      end
   end

   // Memory: one write, one registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.rd_direct || cmd.rd_pointer) begin
         rdata_ff <= mem[AddrBits'(rd_addr_w)];
      end
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.rd_pointer) begin
         ptr_ff <= rdata_ff;
      end
      prod_ff <= acc_ff * rdata_ff;
      rsp_ff  <= rsp_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      qneg_ff <= qneg_in;
   end

   always_comb begin
      taken = 1'b0;
      unique case (req_ff.mode)
         OP_JUMP:     taken = 1'b1;
         OP_JUMPNEG:  taken = acc_ff[WordBits-1];
         OP_JUMPZERO: taken = acc_ff == '0;
         OP_JUMPNZ:   taken = acc_ff != '0;
         default:     taken = 1'b0;
      endcase
   end

   // Divider: restoring, one quotient bit a cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      qneg_in = qneg_ff;
      dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         quo_in  = abs_a;
         rem_in  = '0;
         dvs_in  = abs_b;
         qneg_in = acc_ff[WordBits-1] ^ rdata_ff[WordBits-1];
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         dcnt_in = dcnt_ff + 1'b1;
         if (!trial[WordBits]) begin
            rem_in = trial[WordBits-1:0];
            quo_in = {quo_ff[WordBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WordBits-2:0], quo_ff[WordBits-1]};
            quo_in = {quo_ff[WordBits-2:0], 1'b0};
         end
      end
   end

   // Architectural state and response.
   always_comb begin
      acc_in = acc_ff;
      pc_in  = pc_ff;
      rsp_in = rsp_ff;
      clr_in = clr_ff;
      if (cmd.clear_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.execute) begin
         rsp_in.status       = ST_OK;
         rsp_in.memory_word  = '0;
         rsp_in.branch_taken = 1'b0;
         pc_in = pc_inc;
         if (req_ff.mode <= OP_STOREIND && !addr_ok) begin
            rsp_in.status = ST_RANGE;
         end else begin
            unique case (req_ff.mode)
               OP_READ:  rsp_in.memory_word = req_ff.in_value;
               OP_LOAD: begin
                  acc_in = rdata_ff;
                  rsp_in.memory_word = rdata_ff;
               end
               OP_STORE: rsp_in.memory_word = acc_ff;
               OP_ADD: begin
                  acc_in = acc_ff + rdata_ff;
                  rsp_in.memory_word = rdata_ff;
               end
               OP_SUB: begin
                  acc_in = acc_ff - rdata_ff;
                  rsp_in.memory_word = rdata_ff;
               end
               OP_DIV: begin
                  rsp_in.memory_word = rdata_ff;
                  if (rdata_ff == '0) begin
                     rsp_in.status = ST_DIV0;
                  end
               end
               OP_MUL: rsp_in.memory_word = rdata_ff;
               OP_JUMP, OP_JUMPNEG, OP_JUMPZERO, OP_JUMPNZ: begin
                  rsp_in.branch_taken = taken;
                  if (taken) begin
                     pc_in = req_ff.operand_address;
                  end
               end
               default: rsp_in.memory_word = '0;
            endcase
         end
      end
      // Finish an indirect access: pointer in ptr_ff, target word in rdata_ff.
      if (cmd.exec_ind) begin
         rsp_in.status       = ST_OK;
         rsp_in.branch_taken = 1'b0;
         pc_in = pc_inc;
         if (!ptr_ok) begin
            rsp_in.status = ST_RANGE;
            rsp_in.memory_word = ptr_ff;
         end else if (req_ff.mode == OP_LOADIND) begin
            acc_in = rdata_ff;
            rsp_in.memory_word = rdata_ff;
         end else begin
            rsp_in.memory_word = acc_ff;
         end
      end
      if (cmd.div_finish) begin
         acc_in = qres;
      end
      if (cmd.mul_finish) begin
         acc_in = prod_ff;
      end
      rsp_in.accumulator_out = acc_in;
      rsp_in.next_pc = pc_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         pc_ff       <= '0;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         dcnt_ff     <= '0;
      end else begin
         acc_ff  <= acc_in;
         pc_ff   <= pc_in;
         clr_ff  <= clr_in;
         dcnt_ff <= dcnt_in;
         if (cmd.clear_step && clr_ff == AddrBits'(MemWords - 1)) begin
            clr_done_ff <= 1'b1;
         end
      end
   end

   assign sts.clear_done = clr_done_ff;
   assign sts.div_last   = dcnt_ff == CntBits'(WordBits - 1);
   assign sts.mode       = req_ff.mode;
   assign sts.addr_ok    = addr_ok;
   assign sts.div_zero   = rdata_ff == '0;
   assign result         = rsp_ff;
endmodule
`default_nettype wire

@@ hdl/ame_control.sv @@
// Controller: sequences clearing, memory reads, execution and the handshakes.
`default_nettype none
module ame_control (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire ame_pkg::sts_type sts,
   output ame_pkg::cmd_type      cmd
);
   import ame_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_IEXEC = 4'd4;
   localparam logic [3:0] S_DSTEP = 4'd5;
   localparam logic [3:0] S_DFIN  = 4'd6;
   localparam logic [3:0] S_MFIN  = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       rvalid_ff, rvalid_in;
   logic       accept, done;

   assign req_stall = !(state_ff == S_IDLE) || (rvalid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rvalid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               cmd.clear_step = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_direct = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            priority if (!sts.addr_ok && sts.mode <= OP_STOREIND) begin
               done = 1'b1;
               state_in = S_IDLE;
            end else if (sts.mode == OP_LOADIND || sts.mode == OP_STOREIND) begin
               // pointer word is in rdata; fetch the target
               cmd.execute = 1'b0;
               cmd.rd_pointer = 1'b1;
               state_in = S_IEXEC;
            end else if (sts.mode == OP_DIV && !sts.div_zero) begin
               cmd.div_start = 1'b1;
               state_in = S_DSTEP;
            end else if (sts.mode == OP_MUL) begin
               state_in = S_MFIN;
            end else begin
               done = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_IEXEC: begin
            cmd.exec_ind = 1'b1;
            done = 1'b1;
            state_in = S_IDLE;
         end
         S_DSTEP: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            cmd.div_finish = 1'b1;
            done = 1'b1;
            state_in = S_IDLE;
         end
         S_MFIN: begin
            cmd.mul_finish = 1'b1;
            done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (rvalid_ff && !rsp_stall) begin
         rvalid_in = 1'b0;
      end
      if (done) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/accumulator_machine_execute_top.sv @@
// Top level: accumulator machine executing one instruction per request transfer.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | ame_pkg::req_type
//  rsp     | out       | rsp_valid/stall   | ame_pkg::rsp_type
//
// After reset the word memory is cleared one word a cycle; requests stall until clearing is done.
// From one request transfer to the next, with no result stall, simple operations
// and faults pass S_READ and S_EXEC; multiply adds S_MFIN, indirect adds S_IEXEC,
// and divide adds the 32-step restoring divider in S_DSTEP, then S_DFIN.
// A result waits in the output register; requests stall while an instruction
// is in flight and while a finished result is stalled.
`default_nettype none
module accumulator_machine_execute_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ame_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ame_pkg::rsp_type      rsp_data
);
   import ame_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ame_control u_control (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   ame_datapath u_datapath (
      .clock, .reset, .req(req_data), .cmd, .sts, .result(rsp_data)
   );
endmodule
`default_nettype wire

@@ hdl/ame_checker.sv @@
// Checker: port-level properties of the accumulator machine, bound to the top.
`default_nettype none
module ame_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire ame_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ame_pkg::rsp_type rsp_data
);
   import ame_pkg::*;

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Stall the cycle after a request transfer.
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken twice in a row");

   // Counter stays in memory range.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.next_pc < 7'(MemWords))
      else $error("next_pc out of range");

   // Status code legal.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("bad status");
endmodule

bind accumulator_machine_execute_top ame_checker u_ame_checker (.*);
`default_nettype wire
